>>> rtl/brle_pkg.sv
// Package for the byte ring line extractor: sizes, codes, result types and helpers.
package brle_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int MAX_LINE  = 64;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int LEN_W     = 6;
    localparam int LIM_W     = 7;
    localparam int FILL_W    = 10;
    localparam int OFF_W     = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_LINE = 2'd2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOLINE,
        ST_BADLIM
    } t_status;

    typedef struct packed {
        logic [7:0]        data;
        logic              data_valid;
        logic              last;
        t_status           status;
        logic [LEN_W-1:0]  line_length;
        logic [FILL_W-1:0] fill_level;
    } t_result;

    // memory port request from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } t_mem_req;

    // output queue status seen by the sequencer
    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } t_q_stat;

    // pointer step with wrap at the ring depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(BUF_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // pointer advance by n < depth, one compare and subtract
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (PTR_W+1)'(BUF_DEPTH)) begin
            s = s - (PTR_W+1)'(BUF_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // fill level field: count zero-extended or cut to the field width
    function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] cnt);
        logic [PTR_W+FILL_W-1:0] w;
        w = {{FILL_W{1'b0}}, cnt};
        return w[FILL_W-1:0];
    endfunction

    function automatic t_result mk_result(input logic v, input logic lst,
                                          input t_status st,
                                          input logic [LEN_W-1:0] len,
                                          input logic [FILL_W-1:0] fill);
        t_result r;
        r.data        = 8'h00;
        r.data_valid  = v;
        r.last        = lst;
        r.status      = st;
        r.line_length = len;
        r.fill_level  = fill;
        return r;
    endfunction

endpackage

>>> rtl/brle_ring_mem.sv
// Byte ring storage: one write port, one read port with registered read data.
module brle_ring_mem (
    input  logic              i_clk,
    input  brle_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);
    import brle_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/brle_out_q.sv
// Two-entry result queue in front of the output channel.
module brle_out_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  brle_pkg::t_result i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output brle_pkg::t_result o_head,
    output brle_pkg::t_q_stat o_stat
);
    import brle_pkg::*;

    logic [1:0] r_occ, n_occ;
    t_result    r_e0, n_e0;
    t_result    r_e1, n_e1;
    logic       pop;

    assign o_valid = (r_occ != 2'd0);
    assign pop     = o_valid && !i_stall;

    // shift-register queue update
    always_comb begin
        n_occ = r_occ;
        n_e0  = r_e0;
        n_e1  = r_e1;
        priority if (i_push && pop) begin
            if (r_occ == 2'd1) begin
                n_e0 = i_data;
            end else begin
                n_e0 = r_e1;
                n_e1 = i_data;
            end
        end else if (i_push) begin
            n_occ = r_occ + 2'd1;
            if (r_occ == 2'd0) begin
                n_e0 = i_data;
            end else begin
                n_e1 = i_data;
            end
        end else if (pop) begin
            n_occ = r_occ - 2'd1;
            n_e0  = r_e1;
        end else begin
            // nothing moves
            n_occ = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

    assign o_head     = r_e0;
    assign o_stat.occ = r_occ;
    assign o_stat.pop = pop;

endmodule

>>> rtl/brle_ctrl.sv
// Sequencer: pointers, fill count, push/pop, line scan, CR/LF check and line copy.
module brle_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [7:0]                 i_byte_in,
    input  logic [brle_pkg::LIM_W-1:0] i_line_limit,
    input  brle_pkg::t_q_stat          i_q,
    output logic                       o_q_push,
    output brle_pkg::t_result          o_q_data,
    output brle_pkg::t_mem_req         o_mem,
    input  logic [7:0]                 i_rd_data
);
    import brle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TERM,
        S_EMIT,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_saddr, n_saddr;
    logic [PTR_W-1:0]  r_off, n_off;
    logic [PTR_W-1:0]  r_pos, n_pos;
    logic [PTR_W-1:0]  r_drop, n_drop;
    logic [PTR_W-1:0]  r_eaddr, n_eaddr;
    logic [LEN_W-1:0]  r_lim_m1, n_lim_m1;
    logic [LEN_W-1:0]  r_copy, n_copy;
    logic [LEN_W-1:0]  r_j, n_j;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_result           r_fin, n_fin;
    logic              r_res_valid, n_res_valid;
    logic              r_res_mem, n_res_mem;
    t_result           r_res, n_res;

    logic [2:0]        q_sum;
    logic              room;
    logic              accept;
    logic [LIM_W-1:0]  lim_sat;
    logic              is_term;

    // space check: queue plus the result stage, less what leaves this cycle
    assign q_sum  = 3'(i_q.occ) + 3'(r_res_valid) - 3'(i_q.pop);
    assign room   = (q_sum <= 3'd1);
    assign o_stall = !((r_state == S_IDLE) && room);
    assign accept  = i_valid && !o_stall;

    assign lim_sat = (i_line_limit > LIM_W'(MAX_LINE)) ? LIM_W'(MAX_LINE) : i_line_limit;
    assign is_term = (i_rd_data == CH_LF) || (i_rd_data == CH_CR);

    function automatic logic [LEN_W-1:0] copy_of(input logic [PTR_W-1:0] pos,
                                                 input logic [LEN_W-1:0] lm1);
        if (OFF_W'(pos) < OFF_W'(lm1)) begin
            return LEN_W'(pos);
        end
        return lm1;
    endfunction

    always_comb begin
        logic             go_line;
        logic [PTR_W-1:0] drop_v;
        logic [LEN_W-1:0] copy_v;
        logic [PTR_W-1:0] left_v;

        go_line = 1'b0;
        drop_v  = '0;
        copy_v  = '0;
        left_v  = '0;

        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_count     = r_count;
        n_saddr     = r_saddr;
        n_off       = r_off;
        n_pos       = r_pos;
        n_drop      = r_drop;
        n_eaddr     = r_eaddr;
        n_lim_m1    = r_lim_m1;
        n_copy      = r_copy;
        n_j         = r_j;
        n_fill      = r_fill;
        n_fin       = r_fin;
        n_res_valid = 1'b0;
        n_res_mem   = 1'b0;
        n_res       = r_res;

        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_wp;
        o_mem.wr_data = i_byte_in;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = r_rp;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_PUSH: begin
                            n_res_valid = 1'b1;
                            if (r_count == PTR_W'(BUF_DEPTH - 1)) begin
                                n_res = mk_result(1'b0, 1'b1, ST_FULL, '0, fill_of(r_count));
                            end else begin
                                o_mem.wr_en = 1'b1;
                                n_wp        = ptr_inc(r_wp);
                                n_count     = r_count + PTR_W'(1);
                                n_res = mk_result(1'b0, 1'b1, ST_OK, '0,
                                                  fill_of(r_count + PTR_W'(1)));
                            end
                        end
                        ACT_POP: begin
                            n_res_valid = 1'b1;
                            if (r_count == '0) begin
                                n_res = mk_result(1'b0, 1'b1, ST_EMPTY, '0, fill_of(r_count));
                            end else begin
                                o_mem.rd_en = 1'b1;
                                n_res_mem   = 1'b1;
                                n_rp        = ptr_inc(r_rp);
                                n_count     = r_count - PTR_W'(1);
                                n_res = mk_result(1'b1, 1'b1, ST_OK, '0,
                                                  fill_of(r_count - PTR_W'(1)));
                            end
                        end
                        ACT_LINE: begin
                            priority if (lim_sat < LIM_W'(2)) begin
                                n_res_valid = 1'b1;
                                n_res = mk_result(1'b0, 1'b1, ST_BADLIM, '0, fill_of(r_count));
                            end else if (r_count == '0) begin
                                n_res_valid = 1'b1;
                                n_res = mk_result(1'b0, 1'b1, ST_NOLINE, '0, fill_of(r_count));
                            end else begin
                                // start the scan at the oldest byte
                                o_mem.rd_en = 1'b1;
                                n_saddr     = ptr_inc(r_rp);
                                n_off       = '0;
                                n_lim_m1    = LEN_W'(lim_sat - LIM_W'(1));
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: no result, no change
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // one byte checked per cycle; next read always issued
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_saddr;
                n_saddr       = ptr_inc(r_saddr);
                n_off         = r_off + PTR_W'(1);
                if (is_term) begin
                    n_pos  = r_off;
                    n_copy = copy_of(r_off, r_lim_m1);
                    if ((i_rd_data == CH_CR) &&
                        (({1'b0, r_off} + (PTR_W+1)'(1)) < {1'b0, r_count})) begin
                        n_state = S_TERM;
                    end else begin
                        go_line = 1'b1;
                        drop_v  = r_off + PTR_W'(1);
                        copy_v  = copy_of(r_off, r_lim_m1);
                    end
                end else if (({1'b0, r_off} + (PTR_W+1)'(1)) == {1'b0, r_count}) begin
                    n_drop  = '0;
                    n_fin   = mk_result(1'b0, 1'b1, ST_NOLINE, '0, fill_of(r_count));
                    n_state = S_FIN;
                end
            end

            S_TERM: begin
                // byte after a CR: an LF there goes with the line
                go_line = 1'b1;
                drop_v  = r_pos + PTR_W'(1) + ((i_rd_data == CH_LF) ? PTR_W'(1) : PTR_W'(0));
                copy_v  = r_copy;
            end

            S_EMIT: begin
                if (room) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_eaddr;
                    n_res_valid   = 1'b1;
                    n_res_mem     = 1'b1;
                    n_res = mk_result(1'b1, (r_j == r_copy - LEN_W'(1)), ST_OK,
                                      r_copy, r_fill);
                    n_eaddr = ptr_inc(r_eaddr);
                    n_j     = r_j + LEN_W'(1);
                    if (r_j == r_copy - LEN_W'(1)) begin
                        n_rp    = ptr_add(r_rp, r_drop);
                        n_count = r_count - r_drop;
                        n_state = S_IDLE;
                    end
                end
            end

            S_FIN: begin
                if (room) begin
                    n_res_valid = 1'b1;
                    n_res       = r_fin;
                    n_rp        = ptr_add(r_rp, r_drop);
                    n_count     = r_count - r_drop;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // line found: set up the copy or the empty-line result
        if (go_line) begin
            left_v = r_count - drop_v;
            n_drop = drop_v;
            n_fill = fill_of(left_v);
            if (copy_v == '0) begin
                n_fin   = mk_result(1'b0, 1'b1, ST_OK, '0, fill_of(left_v));
                n_state = S_FIN;
            end else begin
                n_copy  = copy_v;
                n_j     = '0;
                n_eaddr = r_rp;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_saddr   <= n_saddr;
        r_off     <= n_off;
        r_pos     <= n_pos;
        r_drop    <= n_drop;
        r_eaddr   <= n_eaddr;
        r_lim_m1  <= n_lim_m1;
        r_copy    <= n_copy;
        r_j       <= n_j;
        r_fill    <= n_fill;
        r_fin     <= n_fin;
        r_res_mem <= n_res_mem;
        r_res     <= n_res;
    end

    // result stage: read data joins its fields in the cycle after the read
    always_comb begin
        o_q_data = r_res;
        if (r_res_mem) begin
            o_q_data.data = i_rd_data;
        end
    end

    assign o_q_push = r_res_valid;

endmodule

>>> rtl/byte_ring_line_extractor.sv
// Top level of the byte ring FIFO with CR/LF line framing.
//
//  channel  direction  handshake          payload
//  request  in         i_valid / o_stall  i_action, i_byte_in, i_line_limit
//  result   out        o_valid / i_stall  o_data_out, o_data_valid, o_last,
//                                         o_status, o_line_length, o_fill_level
//
// A push or pop result is registered in the result stage, then in the output queue.
// Read line, requests stalled until done: a start read, a scan read per byte through the
// terminator (every held byte if there is none), one more check after a CR with bytes behind
// it, then one read per copied byte, or a closing result for an empty line or no line.
// Reset is synchronous and clears pointers and fill count; the ring is not cleared.
// A stalled result channel fills a two-entry queue; requests then stall.
module byte_ring_line_extractor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [7:0]                 i_byte_in,
    input  logic [brle_pkg::LIM_W-1:0] i_line_limit,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_data_out,
    output logic                       o_data_valid,
    output logic                       o_last,
    output logic [2:0]                 o_status,
    output logic [brle_pkg::LEN_W-1:0] o_line_length,
    output logic [brle_pkg::FILL_W-1:0] o_fill_level
);
    import brle_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] rd_data;
    t_q_stat    q_stat;
    logic       q_push;
    t_result    q_data;
    t_result    q_head;

    brle_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_byte_in    (i_byte_in),
        .i_line_limit (i_line_limit),
        .i_q          (q_stat),
        .o_q_push     (q_push),
        .o_q_data     (q_data),
        .o_mem        (mem_req),
        .i_rd_data    (rd_data)
    );

    brle_ring_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    brle_out_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    assign o_data_out    = q_head.data;
    assign o_data_valid  = q_head.data_valid;
    assign o_last        = q_head.last;
    assign o_status      = q_head.status;
    assign o_line_length = q_head.line_length;
    assign o_fill_level  = q_head.fill_level;

    // queue never takes a result it has no room for
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && (q_stat.occ == 2'd2)) |-> q_stat.pop)
        else $error("result queue overflow");

    // a request is only taken while the result side can absorb it
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (q_stat.occ != 2'd2 || q_stat.pop))
        else $error("request accepted with full result queue");

    // results of one line carry the same length and fill level
    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=>
        (!o_valid || (o_line_length == $past(o_line_length) &&
                      o_fill_level == $past(o_fill_level))))
        else $error("line fields changed within one request");

    // any non-ok status ends its request
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != 3'(ST_OK))) |-> o_last)
        else $error("error status without last");

endmodule
